[hw/rtl/transposition_table_replace_macros.svh]
// Assertion macros for the transposition table block.
// Included by the RTL file that carries concurrent checks; needs clk and rst_n in scope.
`ifndef TRANSPOSITION_TABLE_REPLACE_MACROS_SVH
`define TRANSPOSITION_TABLE_REPLACE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define TTR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define TTR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TTR_ASSERT_NOW(label, ante, cons, msg)
`define TTR_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[hw/rtl/ttr_pkg.sv]
// Shared types and constants of the transposition table block.
// No dependencies; imported by the top level and the testbench.
package ttr_pkg;

    // table geometry
    localparam int INDEX_BITS  = 14;
    localparam int TABLE_DEPTH = 1 << INDEX_BITS;
    localparam int TAG_LSB     = 48;
    localparam int TAG_BITS    = 16;

    typedef logic [INDEX_BITS-1:0] ttr_index_t;

    // operation codes
    typedef enum logic [1:0] {
        OP_STORE      = 2'd0,
        OP_PROBE      = 2'd1,
        OP_NEW_SEARCH = 2'd2,
        OP_CLEAR      = 2'd3
    } ttr_op_t;

    // bound kinds
    localparam logic [1:0] BOUND_NONE  = 2'd0;
    localparam logic [1:0] BOUND_EXACT = 2'd1;
    localparam logic [1:0] BOUND_LOWER = 2'd2;
    localparam logic [1:0] BOUND_UPPER = 2'd3;

    // one table word, packed tag/depth/score/bound/age/move
    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic signed [7:0]   depth;
        logic signed [15:0]  score;
        logic [1:0]          bound;
        logic [5:0]          age;
        logic [15:0]         move;
    } ttr_entry_t;

    // one result transaction
    typedef struct packed {
        logic               tag_hit;
        logic signed [7:0]  entry_depth;
        logic signed [15:0] entry_score;
        logic [1:0]         entry_bound;
        logic [5:0]         stored_age;
        logic [15:0]        entry_move;
        logic               was_replaced;
    } ttr_result_t;

    // controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } ttr_state_t;

endpackage

[hw/rtl/ttr_in_if.sv]
// Request channel of the transposition table: valid/ready plus the command fields.
// Depends on nothing.
interface ttr_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [63:0]        position_key;
    logic signed [7:0]  search_depth;
    logic signed [15:0] eval_score;
    logic [1:0]         bound_kind;
    logic [15:0]        move_code;

    modport source (
        output valid, operation, position_key, search_depth, eval_score, bound_kind,
               move_code,
        input  ready
    );

    modport sink (
        input  valid, operation, position_key, search_depth, eval_score, bound_kind,
               move_code,
        output ready
    );
endinterface

[hw/rtl/ttr_out_if.sv]
// Result channel of the transposition table: valid/ready plus the entry fields.
// Depends on nothing.
interface ttr_out_if;
    logic               valid;
    logic               ready;
    logic               tag_hit;
    logic signed [7:0]  entry_depth;
    logic signed [15:0] entry_score;
    logic [1:0]         entry_bound;
    logic [5:0]         stored_age;
    logic [15:0]        entry_move;
    logic               was_replaced;

    modport source (
        output valid, tag_hit, entry_depth, entry_score, entry_bound, stored_age,
               entry_move, was_replaced,
        input  ready
    );

    modport sink (
        input  valid, tag_hit, entry_depth, entry_score, entry_bound, stored_age,
               entry_move, was_replaced,
        output ready
    );
endinterface

[hw/rtl/transposition_table_replace.sv]
// Transposition table: direct-mapped store/probe with depth and age replacement.
// The result is registered as the lookup state ends, which waits while a result is held.
// New requests are taken only in the idle state, so never during the read-modify-write
// of the single-port table memory (read on accept, decide and write back in lookup).
// Reset and the clear operation sweep the table, one entry a cycle, over all 16384
// entries (2^INDEX_BITS) with no request accepted; age resets to 0. Depends on ttr_pkg.
`include "transposition_table_replace_macros.svh"

module transposition_table_replace
    import ttr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ttr_in_if.sink    in_ch,
    ttr_out_if.source out_ch
);

    localparam ttr_index_t CLR_LAST = '1;

    // control state
    ttr_state_t  state_reg, state_next;
    ttr_index_t  clr_idx_reg, clr_idx_next;
    logic [5:0]  search_age_reg, search_age_next;
    logic        out_valid_reg, out_valid_next;

    // request payload held for the lookup state
    ttr_op_t             op_reg;
    ttr_index_t          idx_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic signed [7:0]   depth_reg;
    logic signed [15:0]  score_reg;
    logic [1:0]          bound_reg;
    logic [15:0]         move_reg;

    ttr_result_t res_reg, res_next;

    // table memory
    ttr_entry_t mem [TABLE_DEPTH];
    ttr_entry_t rd_data_reg;
    logic       mem_re;
    logic       mem_we;
    ttr_index_t mem_waddr;
    ttr_entry_t mem_wdata;

    logic in_fire;
    logic out_free;
    logic lookup_done;

    // replacement decision
    ttr_entry_t        old_entry;
    ttr_entry_t        new_entry;
    ttr_entry_t        store_entry;
    logic signed [8:0] nd9, od9;
    logic [5:0]        age_delta;
    logic              is_empty;
    logic              same_tag;
    logic              repl_same;
    logic              repl_diff;
    logic              replace;

    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign lookup_done = (state_reg == ST_LOOKUP) && out_free;

    // synchronous table, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[in_ch.position_key[INDEX_BITS-1:0]];
        end
    end

    // replacement rule on the entry just read
    always_comb
    begin
        old_entry = rd_data_reg;
        new_entry = '{tag: tag_reg, depth: depth_reg, score: score_reg, bound: bound_reg,
                      age: search_age_reg, move: move_reg};
        nd9       = {depth_reg[7], depth_reg};
        od9       = {old_entry.depth[7], old_entry.depth};
        age_delta = search_age_reg - old_entry.age;
        is_empty  = (old_entry.tag == '0) && (old_entry.move == '0);
        same_tag  = (old_entry.tag == tag_reg);
        repl_same = (nd9 >= od9) ||
                    ((nd9 + 9'sd1 == od9) && (bound_reg == BOUND_EXACT) &&
                     (old_entry.bound != BOUND_EXACT));
        repl_diff = (age_delta >= 6'd2) || (nd9 >= od9 - 9'sd2) ||
                    ((old_entry.bound == BOUND_UPPER) && (bound_reg != BOUND_UPPER));
        replace   = is_empty || (same_tag ? repl_same : repl_diff);
        store_entry = replace ? new_entry : old_entry;
    end

    // result word by operation
    always_comb
    begin
        res_next = '0;
        unique case (op_reg)
            OP_STORE:
            begin
                res_next.tag_hit      = (store_entry.tag == tag_reg);
                res_next.entry_depth  = store_entry.depth;
                res_next.entry_score  = store_entry.score;
                res_next.entry_bound  = store_entry.bound;
                res_next.stored_age   = store_entry.age;
                res_next.entry_move   = store_entry.move;
                res_next.was_replaced = replace;
            end
            OP_PROBE:
            begin
                res_next.tag_hit      = same_tag;
                res_next.entry_depth  = old_entry.depth;
                res_next.entry_score  = old_entry.score;
                res_next.entry_bound  = old_entry.bound;
                res_next.stored_age   = old_entry.age;
                res_next.entry_move   = old_entry.move;
            end
            OP_NEW_SEARCH, OP_CLEAR:
            begin
                res_next = '0;
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (out_free)
                begin
                    state_next = (op_reg == OP_CLEAR) ? ST_CLEAR : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // controller outputs
    always_comb
    begin
        in_ch.ready     = 1'b0;
        mem_re          = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = new_entry;
        clr_idx_next    = clr_idx_reg;
        search_age_next = search_age_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_idx_reg;
                mem_wdata    = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
            end
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                mem_re      = in_ch.valid;
            end
            ST_LOOKUP:
            begin
                if (out_free)
                begin
                    mem_we = (op_reg == OP_STORE) && replace;
                    if (op_reg == OP_NEW_SEARCH)
                    begin
                        search_age_next = search_age_reg + 1'b1;
                    end
                    if (op_reg == OP_CLEAR)
                    begin
                        search_age_next = '0;
                        clr_idx_next    = '0;
                    end
                end
            end
            default:
            begin
                in_ch.ready = 1'b0;
            end
        endcase
    end

    // result holding register
    always_comb
    begin
        if (lookup_done)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_idx_reg    <= '0;
            search_age_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            search_age_reg <= search_age_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg    <= ttr_op_t'(in_ch.operation);
            idx_reg   <= in_ch.position_key[INDEX_BITS-1:0];
            tag_reg   <= in_ch.position_key[TAG_LSB +: TAG_BITS];
            depth_reg <= in_ch.search_depth;
            score_reg <= in_ch.eval_score;
            bound_reg <= in_ch.bound_kind;
            move_reg  <= in_ch.move_code;
        end
        if (lookup_done)
        begin
            res_reg <= res_next;
        end
    end

    // result channel
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.tag_hit      = res_reg.tag_hit;
    assign out_ch.entry_depth  = res_reg.entry_depth;
    assign out_ch.entry_score  = res_reg.entry_score;
    assign out_ch.entry_bound  = res_reg.entry_bound;
    assign out_ch.stored_age   = res_reg.stored_age;
    assign out_ch.entry_move   = res_reg.entry_move;
    assign out_ch.was_replaced = res_reg.was_replaced;

    // checks
    `TTR_ASSERT_NEXT(a_fire_to_lookup, in_fire, state_reg == ST_LOOKUP,
        "accepted transaction did not start a lookup")
    `TTR_ASSERT_NOW(a_repl_hits, out_ch.valid && out_ch.was_replaced, out_ch.tag_hit,
        "replaced entry reported without a tag hit")
    `TTR_ASSERT_NOW(a_store_writes, lookup_done && op_reg == OP_STORE && replace,
        mem_we && mem_waddr == idx_reg, "replacing store did not write the table")
    `TTR_ASSERT_NEXT(a_clear_sweeps, lookup_done && op_reg == OP_CLEAR,
        state_reg == ST_CLEAR && clr_idx_reg == '0 && search_age_reg == '0,
        "clear did not restart the sweep")
    `TTR_ASSERT_NEXT(a_ctrl_zero, lookup_done &&
        (op_reg == OP_NEW_SEARCH || op_reg == OP_CLEAR),
        out_ch.valid && !out_ch.tag_hit && !out_ch.was_replaced && out_ch.entry_move == '0,
        "age or clear transaction gave a non-zero result")

endmodule

[verif/tb_transposition_table_replace.sv]
// Testbench for the transposition table: drives store, probe, new-search and clear
// transactions and checks every result against a mirror of the table and the age.
// Depends on ttr_pkg, ttr_in_if, ttr_out_if and transposition_table_replace.
module tb_transposition_table_replace;
    timeunit 1ns;
    timeprecision 1ps;

    import ttr_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 10;

    logic clk;
    logic rst_n;

    ttr_in_if  in_ch ();
    ttr_out_if out_ch ();

    transposition_table_replace dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // mirror of the table contents and the search age
    ttr_entry_t  entry_mirror [TABLE_DEPTH];
    logic [5:0]  age_mirror;
    ttr_result_t expected_results [$];

    int          error_count;
    int          cycle_count;
    int          burst_left;
    bit          gaps_enabled;
    bit          hold_request;

    // indexes and tags that random keys favour, so that entries collide
    ttr_index_t  hot_index [8];
    logic [15:0] hot_tag [4];

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    task automatic wipe_mirror();
        foreach (entry_mirror[i])
        begin
            entry_mirror[i] = '0;
        end
        age_mirror = '0;
    endtask

    // work out the result of one accepted request and update the mirror
    task automatic predict_access(input ttr_op_t op, input logic [63:0] key,
                                  input logic signed [7:0] depth,
                                  input logic signed [15:0] score,
                                  input logic [1:0] bound, input logic [15:0] move);
        ttr_index_t  idx;
        logic [15:0] tag;
        ttr_entry_t  slot;
        ttr_result_t res;
        logic [5:0]  age_gap;
        int          old_depth;
        int          new_depth;
        bit          replace;

        idx       = key[INDEX_BITS-1:0];
        tag       = key[63:48];
        slot      = entry_mirror[idx];
        res       = '0;
        replace   = 1'b0;
        old_depth = $signed(slot.depth);
        new_depth = depth;
        age_gap   = age_mirror - slot.age;

        case (op)
            OP_STORE:
            begin
                if (slot.tag == '0 && slot.move == '0)
                    replace = 1'b1;
                else if (slot.tag == tag)
                    replace = (new_depth >= old_depth) ||
                              (new_depth == old_depth - 1 && bound == BOUND_EXACT &&
                               slot.bound != BOUND_EXACT);
                else
                    replace = (age_gap >= 6'd2) || (new_depth >= old_depth - 2) ||
                              (slot.bound == BOUND_UPPER && bound != BOUND_UPPER);
                if (replace)
                begin
                    slot.tag   = tag;
                    slot.depth = depth;
                    slot.score = score;
                    slot.bound = bound;
                    slot.age   = age_mirror;
                    slot.move  = move;
                    entry_mirror[idx] = slot;
                end
            end
            OP_NEW_SEARCH:
            begin
                age_mirror = age_mirror + 6'd1;
            end
            OP_CLEAR:
            begin
                wipe_mirror();
            end
            default:
            begin
            end
        endcase

        // store and probe report the entry, the others report zeros
        if (op == OP_STORE || op == OP_PROBE)
        begin
            res.tag_hit      = (slot.tag == tag);
            res.entry_depth  = slot.depth;
            res.entry_score  = slot.score;
            res.entry_bound  = slot.bound;
            res.stored_age   = slot.age;
            res.entry_move   = slot.move;
            res.was_replaced = replace;
        end
        expected_results.push_back(res);
    endtask

    // offer one request transaction, idling between bursts
    task automatic send_request(input ttr_op_t op, input logic [63:0] key,
                                input logic signed [7:0] depth,
                                input logic signed [15:0] score,
                                input logic [1:0] bound, input logic [15:0] move);
        if (gaps_enabled && burst_left == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            // now and then a long stretch with no idling
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(60, 120);
            else
                burst_left = $urandom_range(1, 24);
        end
        in_ch.valid        <= 1'b1;
        in_ch.operation    <= op;
        in_ch.position_key <= key;
        in_ch.search_depth <= depth;
        in_ch.eval_score   <= score;
        in_ch.bound_kind   <= bound;
        in_ch.move_code    <= move;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        predict_access(op, key, depth, score, bound, move);
        if (burst_left > 0)
            burst_left--;
    endtask

    function automatic logic [63:0] make_key(input logic [15:0] tag, input ttr_index_t idx);
        logic [63:0] k;

        k = {$urandom, $urandom};
        k[63:48] = tag;
        k[INDEX_BITS-1:0] = idx;
        return k;
    endfunction

    function automatic logic [63:0] pick_key();
        logic [63:0] k;

        k = {$urandom, $urandom};
        if ($urandom_range(0, 99) < 85)
            k[INDEX_BITS-1:0] = hot_index[$urandom_range(0, 7)];
        if ($urandom_range(0, 99) < 85)
            k[63:48] = hot_tag[$urandom_range(0, 3)];
        return k;
    endfunction

    function automatic ttr_op_t pick_op(input bit allow_clear);
        int r;

        r = $urandom_range(0, 299);
        if (allow_clear && r == 0)
            return OP_CLEAR;
        else if (r < 165)
            return OP_STORE;
        else if (r < 255)
            return OP_PROBE;
        else
            return OP_NEW_SEARCH;
    endfunction

    // random content: depths mostly close together so the comparisons tie often
    task automatic send_random(input ttr_op_t op);
        logic signed [7:0] depth;
        logic [15:0]       move;

        if ($urandom_range(0, 4) == 0)
            depth = 8'($urandom);
        else
            depth = 8'($urandom_range(0, 12) - 4);
        if ($urandom_range(0, 9) == 0)
            move = '0;
        else
            move = 16'($urandom);
        send_request(op, pick_key(), depth, 16'($urandom), 2'($urandom_range(0, 3)), move);
    endtask

    // probes of a freshly cleared table, tag zero hits the empty slot
    task automatic test_empty_probes();
        send_request(OP_PROBE, 64'd0, 8'sd0, 16'sd0, BOUND_NONE, 16'd0);
        send_request(OP_PROBE, {64{1'b1}}, 8'sd0, 16'sd0, BOUND_NONE, 16'd0);
        send_request(OP_PROBE, make_key(16'h0000, hot_index[3]), 8'sd0, 16'sd0, BOUND_NONE,
                     16'd0);
    endtask

    // walk one entry through each branch of the replacement rule
    task automatic test_replacement();
        ttr_index_t a;

        a = hot_index[2];
        // empty slot, then same-tag cases
        send_request(OP_STORE, make_key(16'h1234, a), 8'sd5, 16'sd100, BOUND_LOWER,
                     16'h0101);
        send_request(OP_STORE, make_key(16'h1234, a), 8'sd4, 16'sd7, BOUND_LOWER, 16'h0202);
        send_request(OP_STORE, make_key(16'h1234, a), 8'sd4, 16'sd8, BOUND_EXACT, 16'h0303);
        send_request(OP_STORE, make_key(16'h1234, a), 8'sd3, 16'sd9, BOUND_EXACT, 16'h0404);
        send_request(OP_STORE, make_key(16'h1234, a), 8'sd127, 16'sd32767, BOUND_NONE,
                     16'hFFFF);
        // different tag: depth margin of two, then upper bound displaced
        send_request(OP_STORE, make_key(16'hABCD, a), 8'sd124, 16'sd1, BOUND_LOWER,
                     16'h1111);
        send_request(OP_STORE, make_key(16'hABCD, a), 8'sd125, 16'sd2, BOUND_UPPER, 16'h2222);
        send_request(OP_STORE, make_key(16'h1234, a), -8'sd128, -16'sd32768, BOUND_LOWER,
                     16'h0000);
        send_request(OP_STORE, make_key(16'h1234, a), 8'sd100, 16'sd3, BOUND_EXACT, 16'h3333);
        // two searches later an old entry gives way to any depth
        send_request(OP_NEW_SEARCH, 64'd0, 8'sd0, 16'sd0, BOUND_NONE, 16'd0);
        send_request(OP_NEW_SEARCH, {64{1'b1}}, -8'sd1, -16'sd1, BOUND_UPPER, 16'hFFFF);
        send_request(OP_STORE, make_key(16'h5555, a), 8'sd0, 16'sd4, BOUND_UPPER, 16'h4444);
        send_request(OP_NEW_SEARCH, 64'd0, 8'sd0, 16'sd0, BOUND_NONE, 16'd0);
        send_request(OP_STORE, make_key(16'h7777, a), -8'sd128, 16'sd5, BOUND_UPPER,
                     16'h5555);
        send_request(OP_PROBE, make_key(16'h5555, a), 8'sd0, 16'sd0, BOUND_NONE, 16'd0);
        send_request(OP_PROBE, make_key(16'h7777, a), 8'sd0, 16'sd0, BOUND_NONE, 16'd0);
        send_request(OP_STORE, {64{1'b1}}, 8'sd127, 16'sd32767, BOUND_UPPER, 16'hFFFF);
    endtask

    // tag zero with move zero still counts as empty after a store
    task automatic test_empty_marker();
        ttr_index_t b;

        b = hot_index[4];
        send_request(OP_STORE, make_key(16'h0000, b), 8'sd9, 16'sd11, BOUND_EXACT, 16'h0000);
        send_request(OP_STORE, make_key(16'h0000, b), -8'sd5, 16'sd12, BOUND_UPPER, 16'h0000);
        send_request(OP_PROBE, make_key(16'h0000, b), 8'sd0, 16'sd0, BOUND_NONE, 16'd0);
    endtask

    // clear empties the table and resets the age
    task automatic test_clear();
        send_request(OP_CLEAR, {$urandom, $urandom}, 8'sd0, 16'sd0, BOUND_NONE, 16'd0);
        send_request(OP_PROBE, make_key(16'h5555, hot_index[2]), 8'sd0, 16'sd0, BOUND_NONE,
                     16'd0);
        send_request(OP_STORE, make_key(16'h0F0F, hot_index[2]), 8'sd1, 16'sd1, BOUND_EXACT,
                     16'h0001);
    endtask

    // enough new searches to wrap the age, with stores and probes in between
    task automatic test_age_wrap();
        repeat (70)
        begin
            send_request(OP_NEW_SEARCH, {$urandom, $urandom}, 8'($urandom), 16'($urandom),
                         2'($urandom_range(0, 3)), 16'($urandom));
            repeat ($urandom_range(1, 2))
            begin
                send_random(ttr_op_t'($urandom_range(0, 1)));
            end
        end
    endtask

    // receiver holds off for a long stretch while requests keep coming
    task automatic test_backpressure();
        gaps_enabled = 1'b0;
        hold_request = 1'b1;
        repeat (40)
        begin
            send_random(ttr_op_t'($urandom_range(0, 1)));
        end
        gaps_enabled = 1'b1;
    endtask

    task automatic test_random_mix();
        repeat (620)
        begin
            send_random(pick_op(1'b1));
        end
    endtask

    // result receiver: stall pattern changes every so often, long hold on request
    initial
    begin : receiver
        int mode;
        int mode_left;
        int hold_left;
        int phase;

        out_ch.ready <= 1'b0;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        phase     = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 150);
            end
            mode_left--;
            phase++;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= 1'($urandom_range(0, 1));
                    2:       out_ch.ready <= (phase % 4) != 3;
                    default: out_ch.ready <= (phase % 4) == 0;
                endcase
            end
        end
    end

    // result checking against the oldest expectation
    always @(posedge clk)
    begin : check_results
        ttr_result_t want;
        bit          bad;

        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("cycle %0d: result transaction with none expected", cycle_count);
            end
            else
            begin
                want = expected_results.pop_front();
                bad  = (out_ch.tag_hit      !== want.tag_hit)     ||
                       (out_ch.entry_depth  !== want.entry_depth) ||
                       (out_ch.entry_score  !== want.entry_score) ||
                       (out_ch.entry_bound  !== want.entry_bound) ||
                       (out_ch.stored_age   !== want.stored_age)  ||
                       (out_ch.entry_move   !== want.entry_move)  ||
                       (out_ch.was_replaced !== want.was_replaced);
                if (bad)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                    begin
                        $display({"cycle %0d: expected hit=%b depth=%0d score=%0d",
                                  " bound=%0d age=%0d move=%h repl=%b"},
                                 cycle_count, want.tag_hit, want.entry_depth, want.entry_score,
                                 want.entry_bound, want.stored_age, want.entry_move,
                                 want.was_replaced);
                        $display({"          got      hit=%b depth=%0d score=%0d",
                                  " bound=%0d age=%0d move=%h repl=%b"},
                                 out_ch.tag_hit, out_ch.entry_depth, out_ch.entry_score,
                                 out_ch.entry_bound, out_ch.stored_age, out_ch.entry_move,
                                 out_ch.was_replaced);
                    end
                end
            end
        end
    end

    // test sequence
    initial
    begin
        rst_n              <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.operation    <= OP_PROBE;
        in_ch.position_key <= '0;
        in_ch.search_depth <= '0;
        in_ch.eval_score   <= '0;
        in_ch.bound_kind   <= '0;
        in_ch.move_code    <= '0;
        error_count  = 0;
        burst_left   = 0;
        gaps_enabled = 1'b1;
        wipe_mirror();

        hot_index[0] = '0;
        hot_index[1] = '1;
        for (int i = 2; i < 8; i++)
        begin
            hot_index[i] = ttr_index_t'($urandom);
        end
        hot_tag[0] = 16'h0000;
        hot_tag[1] = 16'hFFFF;
        hot_tag[2] = 16'($urandom);
        hot_tag[3] = 16'($urandom);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_probes();
        test_replacement();
        test_empty_marker();
        test_clear();
        test_age_wrap();
        test_backpressure();
        test_random_mix();

        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
